@@ src/tcpa_pkg.sv @@
// Shared types and constants for the two-class priority arbiter with burst limit.
// Used by the interfaces, the queue pointer logic, the scheduler and the top level.
// No dependencies.
package tcpa_pkg;

  localparam int ID_W      = 16;
  localparam int KEY_W     = 8;
  localparam int ENTRY_W   = ID_W + KEY_W;
  localparam int BURST_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [BURST_W-1:0] BURST_LIMIT_RST     = 8'd3;
  localparam logic [KEY_W-1:0]   CLASS_THRESHOLD_RST = 8'd60;
  localparam logic [BURST_W-1:0] BURST_MAX           = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_THRESHOLD = 2'd1;

  typedef enum logic {
    OP_ENQ   = 1'b0,
    OP_SERVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

@@ src/tcpa_if.sv @@
// Handshake channels of the arbiter: request, response and configuration write.
// Depends on tcpa_pkg for payload types and widths.
interface tcpa_req_if import tcpa_pkg::*;;
  logic             valid;
  logic             ready;
  op_t              op;
  logic [ID_W-1:0]  entry_id;
  logic [KEY_W-1:0] class_key;

  modport source (output valid, op, entry_id, class_key, input ready);
  modport sink   (input valid, op, entry_id, class_key, output ready);
endinterface

interface tcpa_rsp_if import tcpa_pkg::*;;
  logic             valid;
  logic             ready;
  status_t          status;
  logic [ID_W-1:0]  served_id;
  logic [KEY_W-1:0] served_key;
  logic             from_priority;

  modport source (output valid, status, served_id, served_key, from_priority, input ready);
  modport sink   (input valid, status, served_id, served_key, from_priority, output ready);
endinterface

interface tcpa_cfg_if import tcpa_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/two_class_priority_arbiter_burst_limit_top.sv @@
// Top level of the two-class priority arbiter with burst limit.
// Depends on tcpa_pkg, tcpa_if.sv, tcpa_ram, tcpa_fifo_ctl and tcpa_sched.
//
// Two circular queues of QUEUE_DEPTH entries ({id, key}) each sit in their own RAM with a
// registered read. An enqueue request and a serve request that finds both queues empty
// have their response registered as they are accepted; a serve request that pops an entry
// passes through the read state, which takes the RAM read of the chosen queue head. A new
// request is taken whenever the block is not waiting on such a read and the response
// register is empty or being drained in the same cycle. Queue storage needs no clearing
// after reset: only entries that were written are ever read. Configuration writes are
// always accepted and should be made while no request is in flight.
module two_class_priority_arbiter_burst_limit_top import tcpa_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  tcpa_req_if.sink   req,
  tcpa_rsp_if.source rsp,
  tcpa_cfg_if.sink   cfg
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  fifo_cmd_t          p_cmd;
  fifo_cmd_t          r_cmd;
  fifo_stat_t         p_stat;
  fifo_stat_t         r_stat;
  logic [PTR_W-1:0]   p_head;
  logic [PTR_W-1:0]   p_tail;
  logic [PTR_W-1:0]   r_head;
  logic [PTR_W-1:0]   r_tail;
  logic [ENTRY_W-1:0] wr_word;
  logic [ENTRY_W-1:0] p_rd_data;
  logic [ENTRY_W-1:0] r_rd_data;

  tcpa_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_p_ram (
    .clk     (clk),
    .wr_en   (p_cmd.push),
    .wr_addr (p_tail),
    .wr_data (wr_word),
    .rd_addr (p_head),
    .rd_data (p_rd_data)
  );

  tcpa_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_r_ram (
    .clk     (clk),
    .wr_en   (r_cmd.push),
    .wr_addr (r_tail),
    .wr_data (wr_word),
    .rd_addr (r_head),
    .rd_data (r_rd_data)
  );

  tcpa_fifo_ctl #(.DEPTH(QUEUE_DEPTH)) u_p_fifo (
    .clk  (clk),
    .rst  (rst),
    .cmd  (p_cmd),
    .stat (p_stat),
    .head (p_head),
    .tail (p_tail)
  );

  tcpa_fifo_ctl #(.DEPTH(QUEUE_DEPTH)) u_r_fifo (
    .clk  (clk),
    .rst  (rst),
    .cmd  (r_cmd),
    .stat (r_stat),
    .head (r_head),
    .tail (r_tail)
  );

  tcpa_sched u_sched (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg),
    .p_stat    (p_stat),
    .r_stat    (r_stat),
    .p_cmd     (p_cmd),
    .r_cmd     (r_cmd),
    .wr_word   (wr_word),
    .p_rd_data (p_rd_data),
    .r_rd_data (r_rd_data)
  );

endmodule

@@ src/tcpa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcpa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/tcpa_fifo_ctl.sv @@
// Head, tail and fill count of one circular queue whose entries live in a tcpa_ram.
// Depends on tcpa_pkg for the command and status structs.
module tcpa_fifo_ctl import tcpa_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fifo_cmd_t                cmd,
  output fifo_stat_t               stat,
  output logic [$clog2(DEPTH)-1:0] head,
  output logic [$clog2(DEPTH)-1:0] tail
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (cmd.push) begin
      tail_next = (tail == LAST) ? '0 : tail + 1'b1;
    end
    if (cmd.pop) begin
      head_next = (head == LAST) ? '0 : head + 1'b1;
    end
    unique case ({cmd.push, cmd.pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty) else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

endmodule

@@ src/tcpa_sched.sv @@
// Request sequencer: classifies enqueues, picks the queue to serve under the burst limit,
// holds the configuration registers and the response register.
// Depends on tcpa_pkg and the channel interfaces in tcpa_if.sv.
module tcpa_sched import tcpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  tcpa_req_if.sink           req,
  tcpa_rsp_if.source         rsp,
  tcpa_cfg_if.sink           cfg,
  input  fifo_stat_t         p_stat,
  input  fifo_stat_t         r_stat,
  output fifo_cmd_t          p_cmd,
  output fifo_cmd_t          r_cmd,
  output logic [ENTRY_W-1:0] wr_word,
  input  logic [ENTRY_W-1:0] p_rd_data,
  input  logic [ENTRY_W-1:0] r_rd_data
);

  state_t             state;
  state_t             state_next;
  logic [BURST_W-1:0] burst_limit;
  logic [KEY_W-1:0]   class_threshold;
  logic [BURST_W-1:0] burst_count;
  logic [BURST_W-1:0] burst_count_next;
  logic               pend_prio;

  logic               out_valid;
  status_t            out_status;
  logic [ID_W-1:0]    out_id;
  logic [KEY_W-1:0]   out_key;
  logic               out_prio;

  logic req_acc;
  logic is_serve;
  logic to_prio;
  logic enq_full;
  logic have_p;
  logic have_r;
  logic pick_r;
  logic pick_p;
  logic serve_hit;

  assign req_acc   = req.valid && req.ready;
  assign is_serve  = (req.op == OP_SERVE);
  assign to_prio   = (req.class_key > class_threshold);
  assign enq_full  = to_prio ? p_stat.full : r_stat.full;
  assign have_p    = !p_stat.empty;
  assign have_r    = !r_stat.empty;
  // regular wins when it is alone or the priority burst has run out
  assign pick_r    = have_r && (!have_p || (burst_count >= burst_limit));
  assign pick_p    = have_p && !pick_r;
  assign serve_hit = have_p || have_r;
  assign wr_word   = {req.entry_id, req.class_key};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_acc && is_serve && serve_hit) state_next = S_READ;
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and queue commands
  always_comb begin
    req.ready = 1'b0;
    p_cmd     = '0;
    r_cmd     = '0;
    unique case (state)
      S_IDLE: begin
        req.ready = !out_valid || rsp.ready;
        if (req_acc) begin
          if (is_serve) begin
            p_cmd.pop = pick_p;
            r_cmd.pop = pick_r;
          end else begin
            p_cmd.push = to_prio && !enq_full;
            r_cmd.push = !to_prio && !enq_full;
          end
        end
      end
      S_READ: req.ready = 1'b0;
      default: req.ready = 1'b0;
    endcase
  end

  always_comb begin
    burst_count_next = burst_count;
    if (req_acc && is_serve) begin
      if (have_p && have_r && pick_p) begin
        burst_count_next = (burst_count == BURST_MAX) ? burst_count : burst_count + 1'b1;
      end else begin
        burst_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      burst_count     <= '0;
      burst_limit     <= BURST_LIMIT_RST;
      class_threshold <= CLASS_THRESHOLD_RST;
      out_valid       <= 1'b0;
    end else begin
      state       <= state_next;
      burst_count <= burst_count_next;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_BURST_LIMIT) begin
          burst_limit <= cfg.data;
        end else if (cfg.index == CFG_CLASS_THRESHOLD) begin
          class_threshold <= cfg.data;
        end
      end
      if ((req_acc && !(is_serve && serve_hit)) || (state == S_READ)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (req_acc) begin
      pend_prio <= pick_p;
    end
    if (state == S_READ) begin
      out_status <= ST_SERVED;
      out_prio   <= pend_prio;
      {out_id, out_key} <= pend_prio ? p_rd_data : r_rd_data;
    end else if (req_acc && !(is_serve && serve_hit)) begin
      out_id   <= '0;
      out_key  <= '0;
      out_prio <= 1'b0;
      if (is_serve) begin
        out_status <= ST_EMPTY;
      end else begin
        out_status <= enq_full ? ST_DROPPED : ST_ENQUEUED;
      end
    end
  end

  assign cfg.ready         = 1'b1;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.served_id     = out_id;
  assign rsp.served_key    = out_key;
  assign rsp.from_priority = out_prio;

  a_read_after_serve: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> $past(req_acc && is_serve && serve_hit))
    else $error("read state without a serve request");

  a_serve_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> out_valid) else $error("serve result not registered");

  a_prio_only_served: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_prio) |-> (out_status == ST_SERVED))
    else $error("priority flag on a non-serve response");

endmodule

@@ sim/two_class_priority_arbiter_burst_limit_top_tb.sv @@
// Self-checking testbench for two_class_priority_arbiter_burst_limit_top: a directed table,
// then randomized request phases under several burst and threshold settings.
// Depends on tcpa_pkg, the channel interfaces in tcpa_if.sv and the top level RTL.
module two_class_priority_arbiter_burst_limit_top_tb import tcpa_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH     = 16;
  localparam int RUN_LIMIT  = 300000;
  localparam int MAX_GAP    = 14;
  localparam int DRAIN_WAIT = 8;

  // register slots with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             prio;
  } outcome_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             fixed;
    outcome_t         want;
  } dir_row_t;

  localparam outcome_t ANY_OUT   = '0;
  localparam outcome_t ENQ_OK    = '{ST_ENQUEUED, 16'h0, 8'h0, 1'b0};
  localparam outcome_t BOTH_IDLE = '{ST_EMPTY, 16'h0, 8'h0, 1'b0};

  localparam int DIR_ROWS = 15;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_SERVE, 16'hFFFF, 8'hFF, 1'b1, BOTH_IDLE},
    '{OP_ENQ,   16'hFFFF, 8'hFF, 1'b1, ENQ_OK},
    '{OP_ENQ,   16'h0000, 8'h00, 1'b1, ENQ_OK},
    '{OP_ENQ,   16'h0001, 8'h3C, 1'b1, ENQ_OK},   // key equal to threshold stays regular
    '{OP_ENQ,   16'h0002, 8'h3D, 1'b1, ENQ_OK},
    '{OP_ENQ,   16'h8000, 8'hC8, 1'b1, ENQ_OK},
    '{OP_ENQ,   16'h0004, 8'h64, 1'b1, ENQ_OK},
    '{OP_SERVE, 16'h0000, 8'h00, 1'b0, ANY_OUT},
    '{OP_SERVE, 16'h0000, 8'h00, 1'b0, ANY_OUT},
    '{OP_SERVE, 16'h0000, 8'h00, 1'b0, ANY_OUT},
    '{OP_SERVE, 16'h0000, 8'h00, 1'b0, ANY_OUT},   // burst limit reached, regular wins
    '{OP_SERVE, 16'h0000, 8'h00, 1'b0, ANY_OUT},
    '{OP_SERVE, 16'h0000, 8'h00, 1'b0, ANY_OUT},
    '{OP_SERVE, 16'h0000, 8'h00, 1'b1, BOTH_IDLE},
    '{OP_SERVE, 16'hAAAA, 8'h55, 1'b1, BOTH_IDLE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcpa_req_if req_ch ();
  tcpa_rsp_if rsp_ch ();
  tcpa_cfg_if cfg_ch ();

  two_class_priority_arbiter_burst_limit_top #(.QUEUE_DEPTH(QDEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  always #2 clk = ~clk;

  // scheduler model state
  entry_t             prio_fifo [$];
  entry_t             reg_fifo [$];
  logic [BURST_W-1:0] burst_cnt;
  logic [BURST_W-1:0] burst_lim;
  logic [KEY_W-1:0]   class_thr;

  outcome_t pending [$];
  bit       req_fixed;
  outcome_t req_want;

  int errors;
  int cycles;
  int n_req;
  int n_rsp;
  int n_status [4];
  int n_forced;
  int longest_run;
  int req_quiet;
  int rsp_quiet;

  task automatic report(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic outcome_t schedule(input op_t op, input logic [ID_W-1:0] id,
                                        input logic [KEY_W-1:0] key);
    outcome_t o;
    entry_t   e;
    o = '0;
    e.id = id;
    e.key = key;
    if (op == OP_ENQ) begin
      o.status = ST_ENQUEUED;
      if (key > class_thr) begin
        if (prio_fifo.size() >= QDEPTH) o.status = ST_DROPPED;
        else prio_fifo.push_back(e);
      end else begin
        if (reg_fifo.size() >= QDEPTH) o.status = ST_DROPPED;
        else reg_fifo.push_back(e);
      end
      return o;
    end
    o.status = ST_SERVED;
    if (prio_fifo.size() != 0 && reg_fifo.size() != 0) begin
      if (burst_cnt >= burst_lim) begin
        e = reg_fifo.pop_front();
        burst_cnt = '0;
        n_forced++;
      end else begin
        e = prio_fifo.pop_front();
        o.prio = 1'b1;
        if (burst_cnt != BURST_MAX) burst_cnt++;
        if (int'(burst_cnt) > longest_run) longest_run = int'(burst_cnt);
      end
    end else if (prio_fifo.size() != 0) begin
      e = prio_fifo.pop_front();
      o.prio = 1'b1;
      burst_cnt = '0;
    end else if (reg_fifo.size() != 0) begin
      e = reg_fifo.pop_front();
      burst_cnt = '0;
    end else begin
      o.status = ST_EMPTY;
      burst_cnt = '0;
      return o;
    end
    o.id = e.id;
    o.key = e.key;
    return o;
  endfunction

  // random wait before a handshake, with occasional runs of back-to-back traffic
  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // capture accepted requests, config writes and responses
  always @(posedge clk) begin : monitor
    outcome_t want;
    outcome_t pred;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_rsp++;
        n_status[rsp_ch.status]++;
        if (pending.size() == 0) begin
          report($sformatf("response %0d with nothing expected", n_rsp));
        end else begin
          want = pending.pop_front();
          if (rsp_ch.status !== want.status)
            report($sformatf("response %0d status %0d, expected %0d",
                             n_rsp, rsp_ch.status, want.status));
          if (rsp_ch.served_id !== want.id)
            report($sformatf("response %0d served_id %h, expected %h",
                             n_rsp, rsp_ch.served_id, want.id));
          if (rsp_ch.served_key !== want.key)
            report($sformatf("response %0d served_key %h, expected %h",
                             n_rsp, rsp_ch.served_key, want.key));
          if (rsp_ch.from_priority !== want.prio)
            report($sformatf("response %0d from_priority %b, expected %b",
                             n_rsp, rsp_ch.from_priority, want.prio));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        n_req++;
        pred = schedule(req_ch.op, req_ch.entry_id, req_ch.class_key);
        pending.push_back(req_fixed ? req_want : pred);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_BURST_LIMIT) burst_lim = cfg_ch.data;
        else if (cfg_ch.index == CFG_CLASS_THRESHOLD) class_thr = cfg_ch.data;
      end
    end
  end

  // response side back-pressure
  initial begin : rsp_stall
    int gap;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = draw_gap(rsp_quiet);
      @(negedge clk);
      if (gap > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  task automatic send_request(input op_t op, input logic [ID_W-1:0] id,
                              input logic [KEY_W-1:0] key, input bit fixed,
                              input outcome_t want);
    int gap;
    gap = draw_gap(req_quiet);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.op = op;
    req_ch.entry_id = id;
    req_ch.class_key = key;
    req_fixed = fixed;
    req_want = want;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // let every outstanding request finish before touching registers
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input bit want_prio);
    if ($urandom_range(0, 9) == 0) return KEY_W'($urandom_range(0, 255));
    if (want_prio && class_thr != BURST_MAX)
      return KEY_W'($urandom_range(class_thr + 1, 255));
    if (want_prio) return KEY_W'($urandom_range(0, 255));
    return KEY_W'($urandom_range(0, class_thr));
  endfunction

  task automatic run_mix(input int items, input int serve_pct, input int prio_pct);
    op_t op;
    for (int i = 0; i < items; i++) begin
      op = ($urandom_range(0, 99) < serve_pct) ? OP_SERVE : OP_ENQ;
      send_request(op, ID_W'($urandom_range(0, 16'hFFFF)),
                   pick_key($urandom_range(0, 99) < prio_pct), 1'b0, ANY_OUT);
    end
  endtask

  // keep the regular queue waiting while priority requests keep arriving,
  // so the burst counter climbs all the way to its ceiling
  task automatic run_long_burst(input int pairs);
    repeat (2) send_request(OP_ENQ, ID_W'($urandom_range(0, 16'hFFFF)), '0, 1'b0, ANY_OUT);
    for (int i = 0; i < pairs; i++) begin
      send_request(OP_ENQ, ID_W'($urandom_range(0, 16'hFFFF)),
                   KEY_W'($urandom_range(1, 255)), 1'b0, ANY_OUT);
      send_request(OP_SERVE, ID_W'($urandom_range(0, 16'hFFFF)),
                   KEY_W'($urandom_range(0, 255)), 1'b0, ANY_OUT);
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op = OP_ENQ;
    req_ch.entry_id = '0;
    req_ch.class_key = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BURST_LIMIT;
    cfg_ch.data = '0;
    req_fixed = 1'b0;
    req_want = ANY_OUT;
    burst_cnt = '0;
    burst_lim = BURST_LIMIT_RST;
    class_thr = CLASS_THRESHOLD_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].id, dir_rows[i].key, dir_rows[i].fixed,
                   dir_rows[i].want);
    drain();

    // zero burst limit: regular always wins when both queues hold entries
    write_reg(CFG_BURST_LIMIT, 8'd0);
    write_reg(CFG_CLASS_THRESHOLD, 8'd128);
    run_mix(70, 45, 50);
    drain();

    write_reg(CFG_BURST_LIMIT, 8'd255);
    write_reg(CFG_CLASS_THRESHOLD, 8'd0);
    run_long_burst(258);
    drain();

    // writes to unused slots must leave both registers alone
    write_reg(CFG_SPARE_2, CFG_DAT_W'($urandom_range(0, 255)));
    write_reg(CFG_SPARE_3, CFG_DAT_W'($urandom_range(0, 255)));
    write_reg(CFG_BURST_LIMIT, CFG_DAT_W'($urandom_range(1, 8)));
    write_reg(CFG_CLASS_THRESHOLD, CFG_DAT_W'($urandom_range(20, 230)));
    run_mix(100, 20, 50);
    run_mix(80, 80, 50);
    drain();

    write_reg(CFG_CLASS_THRESHOLD, 8'd255);
    write_reg(CFG_BURST_LIMIT, CFG_DAT_W'($urandom_range(0, 255)));
    run_mix(40, 45, 50);
    drain();

    write_reg(CFG_BURST_LIMIT, 8'd2);
    write_reg(CFG_CLASS_THRESHOLD, CFG_DAT_W'($urandom_range(0, 255)));
    run_mix(60, 50, 70);
    drain();

    if (pending.size() != 0) report($sformatf("%0d responses never arrived", pending.size()));
    $display("%0d requests and %0d responses: %0d enqueued, %0d served, %0d empty, %0d dropped",
             n_req, n_rsp, n_status[ST_ENQUEUED], n_status[ST_SERVED], n_status[ST_EMPTY],
             n_status[ST_DROPPED]);
    $display("%0d regular grants forced by the burst limit, longest priority run %0d",
             n_forced, longest_run);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
